/* rtl/core/mu8_pkg.sv */
// shared types, constants and the code point encoder for the modified utf-8 to utf-8 unit
// no dependencies; the other files of the unit that use it refer to this package by scoped names
`timescale 1ns / 1ps
`default_nettype none

package mu8_pkg;

	// depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// most output bytes one input beat can cause
	localparam int MAX_BYTES = 6;
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);

	// surrogate tags in the top six bits of a 16-bit unit
	localparam logic [5:0] SUR_HIGH_TAG = 6'b110110;
	localparam logic [5:0] SUR_LOW_TAG  = 6'b110111;

	localparam logic [20:0] SUPP_BASE      = 21'h010000;
	localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

	// input beat
	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_last;
	} in_beat_t;

	// output beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_end;
		logic       stream_end;
		logic       truncated;
	} out_beat_t;

	// everything one input beat produces, as queued for the back
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] data;
		logic [CNT_W-1:0]          cnt;
		logic                      last;
		logic                      trunc;
	} job_t;

	// shortest utf-8 form of one code point
	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      len;
	} enc_t;

	function automatic enc_t enc_cp(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp < 21'h000080) begin
			e.b[0] = cp[7:0];
			e.len  = 3'd1;
		end else if (cp < 21'h000800) begin
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
			e.len  = 3'd2;
		end else if (cp < 21'h010000) begin
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
			e.len  = 3'd3;
		end else begin
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
			e.len  = 3'd4;
		end
		return e;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/mu8_stream_if.sv */
// valid/ready stream channel with a typed payload
// payload types come from mu8_pkg at the point of instantiation
`timescale 1ns / 1ps
`default_nettype none

interface mu8_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/mu8_front.sv */
// front: takes input beats, tracks sequence and surrogate state, builds one job per beat
// depends on mu8_pkg and mu8_stream_if
`timescale 1ns / 1ps
`default_nettype none

module mu8_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	mu8_stream_if.sink       mutf8,
	input  wire logic        full,
	output logic             push,
	output mu8_pkg::job_t    job
);

	// sequence phase codes
	localparam logic [2:0] PH_IDLE        = 3'd0;
	localparam logic [2:0] PH_TWO_LAST    = 3'd1;
	localparam logic [2:0] PH_THREE_MID   = 3'd2;
	localparam logic [2:0] PH_THREE_LAST  = 3'd3;

	// lead byte classes
	localparam logic [1:0] LEAD_ASCII = 2'd0;
	localparam logic [1:0] LEAD_TWO   = 2'd1;
	localparam logic [1:0] LEAD_THREE = 2'd2;
	localparam logic [1:0] LEAD_OTHER = 2'd3;

	logic [2:0]  phase_q, phase_d;
	logic [15:0] unit_q, unit_d;
	logic [9:0]  held_bits_q, held_bits_d;
	logic        held_q, held_d;

	logic        acc;
	logic [7:0]  b;
	logic        last;
	logic [1:0]  lead;
	logic [15:0] unit_full;
	logic        is_high, is_low;
	logic        a_en, b_en, c_en, trunc;
	logic [20:0] a_cp, b_cp, c_cp;
	mu8_pkg::enc_t a_enc, b_enc, c_enc;
	logic [2:0]  len_a, len_b, len_c;

	assign mutf8.ready = !full;
	assign acc  = mutf8.valid && !full;
	assign b    = mutf8.payload.in_byte;
	assign last = mutf8.payload.stream_last;

	// lead byte decode
	always_comb begin
		unique case (b) inside
			[8'h00:8'h7F]: lead = LEAD_ASCII;
			[8'hC0:8'hDF]: lead = LEAD_TWO;
			[8'hE0:8'hEF]: lead = LEAD_THREE;
			default:       lead = LEAD_OTHER;
		endcase
	end

	assign unit_full = unit_q | {10'd0, b[5:0]};
	assign is_high   = unit_full[15:10] == mu8_pkg::SUR_HIGH_TAG;
	assign is_low    = unit_full[15:10] == mu8_pkg::SUR_LOW_TAG;
	assign a_cp      = {5'd0, mu8_pkg::SUR_HIGH_TAG, held_bits_q};

	// next state and the segments to emit: held flush, new code point, end flush
	always_comb begin
		phase_d     = phase_q;
		unit_d      = unit_q;
		held_bits_d = held_bits_q;
		held_d      = held_q;
		a_en        = 1'b0;
		b_en        = 1'b0;
		b_cp        = '0;
		c_en        = 1'b0;
		c_cp        = '0;
		trunc       = 1'b0;
		unique case (phase_q)
			PH_TWO_LAST: begin
				b_en    = 1'b1;
				b_cp    = {10'd0, unit_full[10:0]};
				unit_d  = '0;
				phase_d = PH_IDLE;
			end
			PH_THREE_MID: begin
				unit_d  = unit_q | {4'd0, b[5:0], 6'd0};
				phase_d = PH_THREE_LAST;
			end
			PH_THREE_LAST: begin
				unit_d  = '0;
				phase_d = PH_IDLE;
				if (held_q && is_low) begin
					b_en        = 1'b1;
					b_cp        = mu8_pkg::SUPP_BASE + {1'b0, held_bits_q, unit_full[9:0]};
					held_d      = 1'b0;
					held_bits_d = '0;
				end else begin
					a_en        = held_q;
					held_d      = 1'b0;
					held_bits_d = '0;
					if (is_high) begin
						held_bits_d = unit_full[9:0];
						held_d      = 1'b1;
					end else begin
						b_en = 1'b1;
						b_cp = {5'd0, unit_full};
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				case (lead)
					LEAD_ASCII: begin
						a_en        = held_q;
						held_d      = 1'b0;
						held_bits_d = '0;
						b_en        = 1'b1;
						b_cp        = {13'd0, b};
					end
					LEAD_TWO: begin
						a_en        = held_q;
						held_d      = 1'b0;
						held_bits_d = '0;
						unit_d      = {5'd0, b[4:0], 6'd0};
						phase_d     = PH_TWO_LAST;
					end
					LEAD_THREE: begin
						unit_d  = {b[3:0], 12'd0};
						phase_d = PH_THREE_MID;
					end
					default: begin
						a_en        = held_q;
						held_d      = 1'b0;
						held_bits_d = '0;
						b_en        = 1'b1;
						b_cp        = mu8_pkg::REPLACEMENT_CP;
					end
				endcase
			end
		endcase
		// end of string: drop partial sequence, flush a held surrogate
		if (last) begin
			trunc       = phase_d != PH_IDLE;
			phase_d     = PH_IDLE;
			unit_d      = '0;
			c_en        = held_d;
			c_cp        = {5'd0, mu8_pkg::SUR_HIGH_TAG, held_bits_d};
			held_d      = 1'b0;
			held_bits_d = '0;
		end
	end

	assign a_enc = mu8_pkg::enc_cp(a_cp);
	assign b_enc = mu8_pkg::enc_cp(b_cp);
	assign c_enc = mu8_pkg::enc_cp(c_cp);
	assign len_a = a_en ? a_enc.len : 3'd0;
	assign len_b = b_en ? b_enc.len : 3'd0;
	assign len_c = c_en ? c_enc.len : 3'd0;

	// pack the segments back to back into the job
	always_comb begin
		logic [2:0] pos;
		logic [2:0] off_b;
		logic [2:0] off_c;
		job.data = '0;
		for (int p = 0; p < mu8_pkg::MAX_BYTES; p++) begin
			pos   = 3'(p);
			off_b = pos - len_a;
			off_c = pos - len_a - len_b;
			if (pos < len_a) begin
				job.data[p] = a_enc.b[pos[1:0]];
			end else if (off_b < len_b) begin
				job.data[p] = b_enc.b[off_b[1:0]];
			end else begin
				job.data[p] = c_enc.b[off_c[1:0]];
			end
		end
		job.cnt   = mu8_pkg::CNT_W'(len_a + len_b + len_c);
		job.last  = last;
		job.trunc = trunc;
	end

	assign push = acc && ((job.cnt != '0) || last);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			unit_q      <= '0;
			held_bits_q <= '0;
			held_q      <= 1'b0;
		end else if (acc) begin
			phase_q     <= phase_d;
			unit_q      <= unit_d;
			held_bits_q <= held_bits_d;
			held_q      <= held_d;
		end
	end

	// a two-byte sequence never starts with a surrogate still held
	a_two_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TWO_LAST |-> !held_q)
		else $error("surrogate held during a two-byte sequence");

	// the end of a string leaves everything at rest
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last |=> phase_q == PH_IDLE && !held_q && unit_q == '0)
		else $error("state not cleared after end of string");

	// a beat with nothing to emit is only dropped when it is not the last one
	a_push_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last |-> push)
		else $error("end of string lost");

endmodule

`default_nettype wire

/* rtl/core/mu8_queue.sv */
// short job queue between front and back
// depends on mu8_pkg for the job type
`timescale 1ns / 1ps
`default_nettype none

module mu8_queue #(
	parameter int DEPTH = mu8_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  mu8_pkg::job_t      push_job,
	output logic               full,
	input  wire logic          pop,
	output mu8_pkg::job_t      head_job,
	output logic               empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	mu8_pkg::job_t  store_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = count_q == CW'(DEPTH);
	assign empty    = count_q == '0;
	assign head_job = store_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue underflow");

	a_ptrs_match: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

/* rtl/core/mu8_back.sv */
// back: walks the head job one byte per beat into a registered output
// depends on mu8_pkg and mu8_stream_if
`timescale 1ns / 1ps
`default_nettype none

module mu8_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  mu8_pkg::job_t    head_job,
	input  wire logic        empty,
	output logic             pop,
	mu8_stream_if.source     utf8
);

	logic [mu8_pkg::CNT_W-1:0] idx_q;
	logic                      valid_q;
	mu8_pkg::out_beat_t        beat_q;
	logic                      load;
	logic                      job_end;
	logic                      has_bytes;

	assign has_bytes = head_job.cnt != '0;
	assign job_end   = !has_bytes || (idx_q == head_job.cnt - 1'b1);
	assign load      = !empty && (!valid_q || utf8.ready);
	assign pop       = load && job_end;

	assign utf8.valid   = valid_q;
	assign utf8.payload = beat_q;

	// output register control and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= job_end ? '0 : idx_q + 1'b1;
			end else if (utf8.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			beat_q.out_byte   <= has_bytes ? head_job.data[idx_q] : 8'd0;
			beat_q.byte_valid <= has_bytes;
			beat_q.run_end    <= job_end;
			beat_q.stream_end <= job_end && head_job.last;
			beat_q.truncated  <= job_end && head_job.last && head_job.trunc;
		end
	end

	// mid-job the job must still sit at the head of the queue
	a_mid_job: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> !empty && has_bytes)
		else $error("byte index set with no job at head");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && has_bytes |-> idx_q < head_job.cnt)
		else $error("byte index past end of job");

	a_trunc_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && beat_q.truncated |-> beat_q.stream_end)
		else $error("truncation flag away from end of string");

endmodule

`default_nettype wire

/* rtl/core/modified_utf8_to_utf8_unit.sv */
// Modified UTF-8 to standard UTF-8 transcoder, top level.
// Channels: mutf8 takes one input byte per beat with stream_last on the final
// byte of a string; utf8 gives one result per beat (a byte with byte_valid, or
// a bare end marker), with run_end on the last result of each input beat and
// stream_end/truncated on the last result of a string. Both are valid/ready.
// The first result of an input beat is written into the queue store and then
// into the output register, which drives utf8. Throughput: one input beat
// per cycle while each beat gives at most one result and utf8 does not stall;
// the output side gives one result per cycle while utf8 is ready, so a beat
// with n results holds the back until all n have left (n is at most 6, e.g.
// a lone surrogate followed by a replacement character). A queue of
// QUEUE_DEPTH jobs takes up such bursts; mutf8.ready drops only when it is
// full. Beats that give no result (lead and middle bytes) never enter it.
// When utf8 stalls, the output register holds its beat and the queue fills.
// Reset clears sequence state, held surrogate, queue and output valid at once;
// no settling time is needed after reset.
// Depends on mu8_pkg, mu8_stream_if, mu8_front, mu8_queue, mu8_back.
`timescale 1ns / 1ps
`default_nettype none

module modified_utf8_to_utf8_unit #(
	parameter int QUEUE_DEPTH = mu8_pkg::QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mu8_stream_if.sink   mutf8,
	mu8_stream_if.source utf8
);

	mu8_pkg::job_t push_job;
	mu8_pkg::job_t head_job;
	logic          push, pop, full, empty;

	// classify and build jobs
	mu8_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.mutf8  (mutf8),
		.full   (full),
		.push   (push),
		.job    (push_job)
	);

	// decouple front from back
	mu8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head_job (head_job),
		.empty    (empty)
	);

	// serialise jobs into output beats
	mu8_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.empty    (empty),
		.pop      (pop),
		.utf8     (utf8)
	);

endmodule

`default_nettype wire
